### rtl/chs_pkg.sv
package chs_pkg;

  localparam int CORDIC_STEPS_DEFAULT = 16;
  localparam int ATAN_LEN = 24;
  localparam int CNT_W = 5;

  localparam int OFFSET_W = 17;
  localparam int FRAC_W = 16;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADING_OFFSET = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLEND_FRACTION = 1'd1;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 16'd6554;

  localparam int HEADING_W = 16;
  localparam int YAW_W = 17;
  localparam int COMP_W = 17;

  localparam logic [16:0] FULL_TURN = 17'd36000;
  localparam logic [34:0] ROT_GAIN = 35'd652032874;
  localparam logic [30:0] YAW_FRAC = 31'd1845864090;

  // 2^32 / 36000 is 119304 plus 728 / 1125. The rounding term 18000 / 36000 becomes
  // 562 after the common factor of 32 is dropped, and 30541990 / 2^35 stands for 1 / 1125.
  localparam logic [31:0] BAM_STEP = 32'd119304;
  localparam logic [24:0] BAM_FRAC_STEP = 25'd728;
  localparam logic [24:0] BAM_BIAS = 25'd562;
  localparam logic [24:0] BAM_RECIP = 25'd30541990;

  typedef struct packed {
    logic load_in;
    logic wrap;
    logic div_init;
    logic div_step;
    logic rot_init;
    logic rot_step;
    logic rot_finish;
    logic blend_east;
    logic blend_north;
    logic vec_init;
    logic vec_step;
    logic head;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic wrap_done;
    logic div_done;
    logic iter_done;
  } status_t;

  function automatic logic [31:0] atan_bam(input logic [CNT_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;
      5'd1: r = 32'h12E4051E;
      5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;
      5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;
      5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

### rtl/chs_in_if.sv
interface chs_in_if;
  logic valid;
  logic ready;
  logic [chs_pkg::HEADING_W-1:0] raw_heading;

  modport source (output valid, output raw_heading, input ready);
  modport sink (input valid, input raw_heading, output ready);
endinterface

### rtl/chs_out_if.sv
interface chs_out_if;
  logic valid;
  logic ready;
  logic [chs_pkg::HEADING_W-1:0] smoothed_heading;
  logic signed [chs_pkg::YAW_W-1:0] yaw_angle;

  modport source (output valid, output smoothed_heading, output yaw_angle, input ready);
  modport sink (input valid, input smoothed_heading, input yaw_angle, output ready);
endinterface

### rtl/chs_ctrl.sv
module chs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  chs_pkg::status_t status,
  output chs_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WRAP  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_RINIT = 4'd3;
  localparam logic [3:0] S_ROT   = 4'd4;
  localparam logic [3:0] S_RFIN  = 4'd5;
  localparam logic [3:0] S_BLE   = 4'd6;
  localparam logic [3:0] S_BLN   = 4'd7;
  localparam logic [3:0] S_VINIT = 4'd8;
  localparam logic [3:0] S_VEC   = 4'd9;
  localparam logic [3:0] S_HEAD  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_WRAP;
        end
      end
      S_WRAP: begin
        if (status.wrap_done) begin
          cmd.div_init = 1'b1;
          state_next = S_DIV;
        end else begin
          cmd.wrap = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_next = S_RINIT;
      end
      S_RINIT: begin
        cmd.rot_init = 1'b1;
        state_next = S_ROT;
      end
      S_ROT: begin
        cmd.rot_step = 1'b1;
        if (status.iter_done) state_next = S_RFIN;
      end
      S_RFIN: begin
        cmd.rot_finish = 1'b1;
        state_next = S_BLE;
      end
      S_BLE: begin
        cmd.blend_east = 1'b1;
        state_next = S_BLN;
      end
      S_BLN: begin
        cmd.blend_north = 1'b1;
        state_next = S_VINIT;
      end
      S_VINIT: begin
        cmd.vec_init = 1'b1;
        state_next = S_VEC;
      end
      S_VEC: begin
        cmd.vec_step = 1'b1;
        if (status.iter_done) state_next = S_HEAD;
      end
      S_HEAD: begin
        cmd.head = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // The previous result must have left the output register first.
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= cmd.load_out | (out_valid & ~out_ready);
    end
  end

endmodule

### rtl/chs_datapath.sv
module chs_datapath #(
  parameter int CORDIC_STEPS = chs_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_enable,
  input  logic [chs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [chs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [chs_pkg::HEADING_W-1:0]       raw_heading,
  input  chs_pkg::cmd_t                       cmd,
  output chs_pkg::status_t                    status,
  output logic [chs_pkg::HEADING_W-1:0]       smoothed_heading,
  output logic signed [chs_pkg::YAW_W-1:0]    yaw_angle
);

  localparam int STEPS = (CORDIC_STEPS > chs_pkg::ATAN_LEN) ? chs_pkg::ATAN_LEN : CORDIC_STEPS;
  localparam logic [chs_pkg::CNT_W-1:0] LAST_ITER = chs_pkg::CNT_W'(STEPS - 1);
  localparam logic [chs_pkg::CNT_W-1:0] LAST_DIV = chs_pkg::CNT_W'(0);

  logic signed [chs_pkg::OFFSET_W-1:0] heading_offset;
  logic [chs_pkg::FRAC_W-1:0] blend_fraction;

  logic signed [17:0] h;
  logic [31:0] bam;
  logic [chs_pkg::CNT_W-1:0] cnt;
  logic flip;
  logic signed [34:0] x;
  logic signed [34:0] y;
  logic signed [33:0] z;
  logic signed [chs_pkg::COMP_W-1:0] sin_v;
  logic signed [chs_pkg::COMP_W-1:0] cos_v;
  logic signed [chs_pkg::COMP_W-1:0] east_component;
  logic signed [chs_pkg::COMP_W-1:0] north_component;
  logic [chs_pkg::HEADING_W-1:0] hd;

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_offset <= '0;
      blend_fraction <= chs_pkg::FRAC_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        chs_pkg::REG_HEADING_OFFSET: heading_offset <= $signed(cfg_data);
        chs_pkg::REG_BLEND_FRACTION: blend_fraction <= cfg_data[chs_pkg::FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // Binary angle of h: h * 119304 plus (h * 728 + 562) / 1125, the latter by a
  // reciprocal multiplication that is exact over the whole range of h.
  logic [31:0] div_base;
  logic [24:0] div_num_next;
  logic [24:0] div_num;
  logic [49:0] div_prod;
  logic [14:0] div_quo;
  assign div_base = 32'(h[15:0]) * chs_pkg::BAM_STEP;
  assign div_num_next = 25'(h[15:0]) * chs_pkg::BAM_FRAC_STEP + chs_pkg::BAM_BIAS;
  assign div_prod = 50'(div_num) * 50'(chs_pkg::BAM_RECIP);
  assign div_quo = div_prod[49:35];

  logic [31:0] atan_v;
  logic signed [33:0] atan_s;
  logic signed [34:0] x_sh;
  logic signed [34:0] y_sh;
  assign atan_v = chs_pkg::atan_bam(cnt);
  assign atan_s = $signed({2'b00, atan_v});
  assign x_sh = x >>> cnt;
  assign y_sh = y >>> cnt;

  logic [31:0] rot_a;
  logic rot_flip;
  assign rot_flip = (bam[31:30] == 2'd1) || (bam[31:30] == 2'd2);
  assign rot_a = rot_flip ? (bam - 32'h80000000) : bam;

  logic signed [34:0] x_fin;
  logic signed [34:0] y_fin;
  assign x_fin = flip ? -x : x;
  assign y_fin = flip ? -y : y;

  function automatic logic signed [16:0] to_q15(input logic signed [34:0] v);
    logic signed [34:0] r;
    r = (v + 35'sd16384) >>> 15;
    if (r > 35'sd32768) r = 35'sd32768;
    if (r < -35'sd32768) r = -35'sd32768;
    return r[16:0];
  endfunction

  // Blend as old + f * (new - old), sharing one multiplier between components.
  logic [chs_pkg::FRAC_W-1:0] f_sat;
  logic signed [16:0] f_s;
  logic signed [16:0] bl_new;
  logic signed [16:0] bl_old;
  logic signed [17:0] bl_diff;
  logic signed [34:0] bl_prod;
  logic signed [35:0] bl_acc;
  logic signed [35:0] bl_res;
  assign f_sat = (blend_fraction > 16'd32768) ? 16'd32768 : blend_fraction;
  assign f_s = $signed({1'b0, f_sat});
  assign bl_new = cmd.blend_east ? sin_v : cos_v;
  assign bl_old = cmd.blend_east ? east_component : north_component;
  assign bl_diff = 18'(bl_new) - 18'(bl_old);
  assign bl_prod = bl_diff * f_s;
  assign bl_acc = (36'(bl_old) <<< 15) + 36'(bl_prod) + 36'sd16384;
  assign bl_res = bl_acc >>> 15;

  logic signed [34:0] vx0;
  logic signed [34:0] vy0;
  assign vx0 = 35'(north_component) <<< 14;
  assign vy0 = 35'(east_component) <<< 14;

  logic [47:0] hd_prod;
  logic [15:0] hd_conv;
  logic est_zero;
  assign hd_prod = z[31:0] * 48'(chs_pkg::FULL_TURN) + 48'h80000000;
  assign hd_conv = hd_prod[47:32];
  assign est_zero = (east_component == '0) && (north_component == '0);

  logic [47:0] yaw_prod;
  logic [16:0] yaw_mag;
  assign yaw_prod = hd * chs_pkg::YAW_FRAC + 48'h80000000;
  assign yaw_mag = 17'(hd) + 17'(yaw_prod[47:32]);

  always_ff @(posedge clk) begin
    if (rst) begin
      east_component <= '0;
      north_component <= '0;
    end else begin
      if (cmd.blend_east) east_component <= bl_res[16:0];
      if (cmd.blend_north) north_component <= bl_res[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      h <= 18'($signed({1'b0, raw_heading})) + 18'(heading_offset);
    end else if (cmd.wrap) begin
      if (h < 0) h <= h + $signed({1'b0, chs_pkg::FULL_TURN});
      else h <= h - $signed({1'b0, chs_pkg::FULL_TURN});
    end

    if (cmd.div_init || cmd.rot_init || cmd.vec_init) cnt <= '0;
    else if (cmd.div_step || cmd.rot_step || cmd.vec_step) cnt <= cnt + 1'b1;

    if (cmd.div_init) begin
      div_num <= div_num_next;
      bam <= div_base;
    end else if (cmd.div_step) begin
      bam <= bam + 32'(div_quo);
    end

    if (cmd.rot_init) begin
      x <= chs_pkg::ROT_GAIN;
      y <= '0;
      z <= 34'($signed(rot_a));
      flip <= rot_flip;
    end else if (cmd.rot_step) begin
      if (!z[33]) begin
        x <= x - y_sh;
        y <= y + x_sh;
        z <= z - atan_s;
      end else begin
        x <= x + y_sh;
        y <= y - x_sh;
        z <= z + atan_s;
      end
    end else if (cmd.vec_init) begin
      if (vx0 < 0) begin
        x <= -vx0;
        y <= -vy0;
        z <= 34'h080000000;
      end else begin
        x <= vx0;
        y <= vy0;
        z <= '0;
      end
    end else if (cmd.vec_step) begin
      if (y > 0) begin
        x <= x + y_sh;
        y <= y - x_sh;
        z <= z + atan_s;
      end else begin
        x <= x - y_sh;
        y <= y + x_sh;
        z <= z - atan_s;
      end
    end

    if (cmd.rot_finish) begin
      sin_v <= to_q15(y_fin);
      cos_v <= to_q15(x_fin);
    end

    if (cmd.head) begin
      if (est_zero || (hd_conv >= chs_pkg::FULL_TURN[15:0])) hd <= '0;
      else hd <= hd_conv;
    end

    if (cmd.load_out) begin
      smoothed_heading <= hd;
      yaw_angle <= $signed(17'd0 - yaw_mag);
    end
  end

  assign status.wrap_done = (h >= 0) && (h < $signed({1'b0, chs_pkg::FULL_TURN}));
  assign status.div_done = (cnt == LAST_DIV);
  assign status.iter_done = (cnt == LAST_ITER);

endmodule

### rtl/circular_heading_smoother_unit.sv
// Circular heading smoother: exponential smoothing of a compass heading on the
// unit circle.
// Input channel in_ch carries raw_heading in hundredths of a degree; output
// channel out_ch carries smoothed_heading (0..35999) and yaw_angle (Q3.13 rad).
// Both use valid/ready; a transaction completes when both are high.
// Registers heading_offset (index 0) and blend_fraction (index 1) are written through
// cfg_write_enable/cfg_index/cfg_data; the user must write them only while the block
// is idle, which the block does not enforce. One sample at a time: the heading is
// brought into range by adding or subtracting full turns, multiplied to a binary angle,
// and then run through two CORDIC passes (rotation, then vectoring) that share one
// x/y/z unit; the next input is taken in the cycle after the result is loaded.
// The next sample is taken as soon as the result sits in the output register.
// If the receiver stalls, the finished result waits there; a following sample
// is processed but held before its output until the register frees.
// Synchronous reset clears the estimate to zero, sets heading_offset to 0 and
// blend_fraction to 6554, and empties the output register.
module circular_heading_smoother_unit #(
  parameter int CORDIC_STEPS = chs_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  chs_in_if.sink                          in_ch,
  chs_out_if.source                       out_ch,
  input  logic                            cfg_write_enable,
  input  logic [chs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [chs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  chs_pkg::cmd_t cmd;
  chs_pkg::status_t status;

  chs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  chs_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .raw_heading      (in_ch.raw_heading),
    .cmd              (cmd),
    .status           (status),
    .smoothed_heading (out_ch.smoothed_heading),
    .yaw_angle        (out_ch.yaw_angle)
  );

endmodule
